// ===== hw/rtl/pesi_pkg.sv =====
package pesi_pkg;

  // byte counter width of the packet scanner
  localparam int CountBits = 20;
  // width of the size and offset fields in a result
  localparam int SizeBits = 20;
  localparam int HdrBits = 9;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // byte positions inside the fixed PES header
  localparam logic [CountBits-1:0] PosPrefixEnd = CountBits'(2);
  localparam logic [CountBits-1:0] PosStreamId  = CountBits'(3);
  localparam logic [CountBits-1:0] PosLenHigh   = CountBits'(4);
  localparam logic [CountBits-1:0] PosLenLow    = CountBits'(5);
  localparam logic [CountBits-1:0] PosHdrLen    = CountBits'(8);

  localparam logic [9:0] ShortHeader    = 10'd6;
  localparam logic [9:0] LongHeaderBase = 10'd9;

  // payload flag bits
  localparam int FlagStartCode = 0;
  localparam int FlagAc3Sync   = 1;
  localparam int FlagCodedVid  = 2;
  localparam int FlagRunEnded  = 3;

  localparam logic [7:0] ByteZero    = 8'h00;
  localparam logic [7:0] ByteOne     = 8'h01;
  localparam logic [7:0] ByteAc3Sync0 = 8'h0B;
  localparam logic [7:0] ByteAc3Sync1 = 8'h77;
  localparam logic [7:0] CodeSeqHdr  = 8'hB3;
  localparam logic [7:0] CodeGop     = 8'hB8;

  // stream types from the PMT
  localparam logic [7:0] StUnknown  = 8'h00;
  localparam logic [7:0] StMpeg1Vid = 8'h01;
  localparam logic [7:0] StMpeg2Vid = 8'h02;
  localparam logic [7:0] StMpeg2Alt = 8'h22;
  localparam logic [7:0] StPrivate  = 8'h06;
  localparam logic [7:0] StAc3      = 8'h81;
  localparam logic [7:0] StEac3     = 8'h87;

  // stream ids without optional header fields
  localparam logic [7:0] SidProgMap   = 8'hBC;
  localparam logic [7:0] SidPadding   = 8'hBE;
  localparam logic [7:0] SidPrivate2  = 8'hBF;
  localparam logic [7:0] SidEcm       = 8'hF0;
  localparam logic [7:0] SidEmm       = 8'hF1;
  localparam logic [7:0] SidDsmcc     = 8'hF2;
  localparam logic [7:0] SidH222E     = 8'hF8;
  localparam logic [7:0] SidDirectory = 8'hFF;
  localparam logic [3:0] SidVideoHigh = 4'hE;

  typedef struct packed {
    logic [CountBits-1:0] byte_index;
    logic [7:0]           id_byte;
    logic [7:0]           hdr_extra_len;
    logic [15:0]          declared_len;
    logic [23:0]          recent_bytes;
    logic                 prefix_good;
    logic [1:0]           zero_run;
    logic [3:0]           payload_flags;
    logic                 intra_hit;
    logic [CountBits-1:0] intra_position;
    logic                 overflowed;
  } pkt_state_t;

  typedef struct packed {
    logic                packet_valid;
    logic [HdrBits-1:0]  header_bytes;
    logic [SizeBits-1:0] packet_bytes;
    logic [7:0]          pes_sid;
    logic                long_header;
    logic                mpeg_video;
    logic                ac3_audio;
    logic                coded_video_start;
    logic                intra_found;
    logic [SizeBits-1:0] intra_offset;
    logic                too_long;
  } pes_result_t;

  function automatic logic sid_long(input logic [7:0] sid);
    return sid != SidProgMap && sid != SidPadding && sid != SidPrivate2 &&
           sid != SidEcm && sid != SidEmm && sid != SidDsmcc &&
           sid != SidH222E && sid != SidDirectory;
  endfunction

  function automatic logic sid_video(input logic [7:0] sid);
    return sid[7:4] == SidVideoHigh;
  endfunction

endpackage

// ===== hw/rtl/pesi_byte_if.sv =====
interface pesi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/pesi_res_if.sv =====
interface pesi_res_if;
  logic                          valid;
  logic                          ready;
  logic                          packet_valid;
  logic [pesi_pkg::HdrBits-1:0]  header_bytes;
  logic [pesi_pkg::SizeBits-1:0] packet_bytes;
  logic [7:0]                    pes_sid;
  logic                          long_header;
  logic                          mpeg_video;
  logic                          ac3_audio;
  logic                          coded_video_start;
  logic                          intra_found;
  logic [pesi_pkg::SizeBits-1:0] intra_offset;
  logic                          too_long;

  modport source (
    output valid, input ready,
    output packet_valid, output header_bytes, output packet_bytes, output pes_sid,
    output long_header, output mpeg_video, output ac3_audio, output coded_video_start,
    output intra_found, output intra_offset, output too_long
  );
  modport sink (
    input valid, output ready,
    input packet_valid, input header_bytes, input packet_bytes, input pes_sid,
    input long_header, input mpeg_video, input ac3_audio, input coded_video_start,
    input intra_found, input intra_offset, input too_long
  );
endinterface

// ===== hw/rtl/pes_packet_inspector_top.sv =====
// pes packet inspector
//
// byte_i carries the raw bytes of one PES packet, one byte per transaction,
// with last_byte set on the final byte. res_o carries one result transaction
// per packet, issued after the final byte: validity of the 00 00 01 prefix,
// header size and declared length, header and effective sizes, stream id,
// payload kind (MPEG-1/2 video, AC-3, coded video start) and the offset of
// the first sequence header or GOP start code.
// stream_type_i is the PMT stream type of the PID, written with
// stream_type_we_i between packets.
// throughput: one byte per cycle unless a final byte waits on res_o; each
// byte passes an input register and a single stage of compares and counter
// updates. the result is valid in the cycle after the final byte leaves the
// input register.
// when res_o stalls, the held result stays put; payload bytes keep flowing
// until a second final byte reaches the input register, which then waits.
// reset clears the packet state, the stream type and both valid flags.
// a packet longer than the byte counter reports only too_long.
module pes_packet_inspector_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stream_type_we_i,
  input  logic [7:0]          stream_type_i,
  pesi_byte_if.sink           byte_i,
  pesi_res_if.source          res_o
);

  // stream type register
  logic [7:0] stream_type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_type_q <= '0;
    end else if (stream_type_we_i) begin
      stream_type_q <= stream_type_i;
    end
  end

  // input register stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       res_free;
  logic       step_go;

  // a final byte may only step once the result register can take it
  assign res_free = !res_o.valid || res_o.ready;
  assign step_go = in_valid_q && (!in_last_q || res_free);
  assign byte_i.ready = !in_valid_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.last_byte;
    end
  end

  // packet scan state
  pesi_pkg::pkt_state_t  state_q;
  pesi_pkg::pkt_state_t  state_d;
  pesi_pkg::pes_result_t result_d;

  pesi_byte_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_byte_q),
    .last_byte_i   (in_last_q),
    .stream_type_i (stream_type_q),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  // result register
  logic                  res_valid_q;
  pesi_pkg::pes_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_go && in_last_q) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && in_last_q) begin
      res_q <= result_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.packet_valid      = res_q.packet_valid;
  assign res_o.header_bytes      = res_q.header_bytes;
  assign res_o.packet_bytes      = res_q.packet_bytes;
  assign res_o.pes_sid           = res_q.pes_sid;
  assign res_o.long_header       = res_q.long_header;
  assign res_o.mpeg_video        = res_q.mpeg_video;
  assign res_o.ac3_audio         = res_q.ac3_audio;
  assign res_o.coded_video_start = res_q.coded_video_start;
  assign res_o.intra_found       = res_q.intra_found;
  assign res_o.intra_offset      = res_q.intra_offset;
  assign res_o.too_long          = res_q.too_long;

endmodule

// ===== hw/rtl/pesi_byte_step.sv =====
module pesi_byte_step (
  input  pesi_pkg::pkt_state_t  state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic [7:0]            stream_type_i,
  output pesi_pkg::pkt_state_t  state_o,
  output pesi_pkg::pes_result_t result_o
);

  localparam int CB = pesi_pkg::CountBits;

  pesi_pkg::pkt_state_t nxt;

  // per-byte scan
  always_comb begin
    logic [CB-1:0] idx;
    logic [9:0]    hs;
    logic [CB-1:0] hs_w;
    logic          in_bounds;
    logic          active;
    logic          is_code;
    idx = state_i.byte_index;
    nxt = state_i;
    hs = '0;
    hs_w = '0;
    in_bounds = 1'b0;
    active = 1'b0;
    is_code = 1'b0;
    if (!state_i.overflowed) begin
      if (idx == pesi_pkg::CountMax) begin
        nxt.overflowed = 1'b1;
      end else begin
        if (idx == pesi_pkg::PosPrefixEnd) begin
          nxt.prefix_good = state_i.recent_bytes[15:0] == 16'h0000 &&
                            data_byte_i == pesi_pkg::ByteOne;
        end
        if (idx == pesi_pkg::PosStreamId) nxt.id_byte = data_byte_i;
        if (idx == pesi_pkg::PosLenHigh) nxt.declared_len[15:8] = data_byte_i;
        if (idx == pesi_pkg::PosLenLow) nxt.declared_len[7:0] = data_byte_i;
        if (idx == pesi_pkg::PosHdrLen) nxt.hdr_extra_len = data_byte_i;

        hs = pesi_pkg::sid_long(nxt.id_byte) ?
             pesi_pkg::LongHeaderBase + {2'b00, nxt.hdr_extra_len} :
             pesi_pkg::ShortHeader;
        hs_w = CB'(hs);
        in_bounds = nxt.declared_len == 16'h0000 ||
                    idx < CB'({1'b0, nxt.declared_len} + 17'(pesi_pkg::ShortHeader));
        active = idx >= CB'(pesi_pkg::ShortHeader) && idx >= hs_w && in_bounds;

        if (active) begin
          if (idx == hs_w + CB'(1) &&
              state_i.recent_bytes[7:0] == pesi_pkg::ByteAc3Sync0 &&
              data_byte_i == pesi_pkg::ByteAc3Sync1) begin
            nxt.payload_flags[pesi_pkg::FlagAc3Sync] = 1'b1;
          end
          if (idx == hs_w + CB'(2) && state_i.recent_bytes[15:0] == 16'h0000 &&
              data_byte_i == pesi_pkg::ByteOne) begin
            nxt.payload_flags[pesi_pkg::FlagStartCode] = 1'b1;
          end
          // leading zero run, saturating at three
          if (!state_i.payload_flags[pesi_pkg::FlagRunEnded]) begin
            if (data_byte_i == pesi_pkg::ByteZero) begin
              if (state_i.zero_run != 2'd3) nxt.zero_run = state_i.zero_run + 2'd1;
            end else begin
              nxt.payload_flags[pesi_pkg::FlagRunEnded] = 1'b1;
              if (data_byte_i == pesi_pkg::ByteOne && state_i.zero_run == 2'd3) begin
                nxt.payload_flags[pesi_pkg::FlagCodedVid] = 1'b1;
              end
            end
          end
          // payload start counts as a start code position
          is_code = data_byte_i == pesi_pkg::CodeSeqHdr || data_byte_i == pesi_pkg::CodeGop;
          if (!state_i.intra_hit && idx >= hs_w + CB'(3) && is_code &&
              (idx == hs_w + CB'(3) || state_i.recent_bytes == 24'h000001)) begin
            nxt.intra_hit = 1'b1;
            nxt.intra_position = idx - CB'(3);
          end
        end
        nxt.recent_bytes = {state_i.recent_bytes[15:0], data_byte_i};
      end
    end
  end

  // end of packet report and next state
  always_comb begin
    logic [CB:0] total;
    logic [CB:0] hs_x;
    logic [CB:0] psize;
    logic [CB:0] esize;
    logic [9:0]  hs;
    logic        lh;
    logic        vid;
    logic        valid;
    logic        mpeg;
    logic        ac3;
    logic        coded;
    total = {1'b0, nxt.byte_index} + (CB+1)'(1);
    psize = (CB+1)'({1'b0, nxt.declared_len} + 17'(pesi_pkg::ShortHeader));
    lh = pesi_pkg::sid_long(nxt.id_byte);
    vid = pesi_pkg::sid_video(nxt.id_byte);
    hs = '0;
    if (nxt.prefix_good && total >= (CB+1)'(pesi_pkg::ShortHeader)) begin
      if (!lh) begin
        hs = pesi_pkg::ShortHeader;
      end else if (total >= (CB+1)'(pesi_pkg::LongHeaderBase)) begin
        hs = pesi_pkg::LongHeaderBase + {2'b00, nxt.hdr_extra_len};
        if ((CB+1)'(hs) > total) hs = '0;
      end
    end
    hs_x = (CB+1)'(hs);
    valid = hs != 10'd0 &&
            (nxt.declared_len == 16'h0000 || (psize >= hs_x && psize <= total));
    esize = nxt.declared_len == 16'h0000 ? total : psize;
    mpeg = esize >= hs_x + (CB+1)'(3) &&
           (stream_type_i == pesi_pkg::StMpeg1Vid || stream_type_i == pesi_pkg::StMpeg2Vid ||
            stream_type_i == pesi_pkg::StMpeg2Alt ||
            (stream_type_i == pesi_pkg::StUnknown && vid &&
             nxt.payload_flags[pesi_pkg::FlagStartCode]));
    ac3 = esize >= hs_x + (CB+1)'(2) &&
          (stream_type_i == pesi_pkg::StAc3 || stream_type_i == pesi_pkg::StEac3 ||
           ((stream_type_i == pesi_pkg::StUnknown || stream_type_i == pesi_pkg::StPrivate) &&
            nxt.payload_flags[pesi_pkg::FlagAc3Sync]));
    coded = stream_type_i == pesi_pkg::StUnknown && vid &&
            nxt.payload_flags[pesi_pkg::FlagCodedVid];

    result_o = '0;
    if (nxt.overflowed) begin
      result_o.too_long = 1'b1;
    end else if (valid) begin
      result_o.packet_valid = 1'b1;
      result_o.header_bytes = hs[pesi_pkg::HdrBits-1:0];
      result_o.packet_bytes = pesi_pkg::SizeBits'(esize);
      result_o.pes_sid = nxt.id_byte;
      result_o.long_header = lh;
      result_o.mpeg_video = mpeg;
      result_o.ac3_audio = ac3;
      result_o.coded_video_start = coded;
      if (mpeg && nxt.intra_hit) begin
        result_o.intra_found = 1'b1;
        result_o.intra_offset = pesi_pkg::SizeBits'(nxt.intra_position);
      end
    end

    state_o = nxt;
    if (last_byte_i) begin
      state_o = '0;
    end else if (!nxt.overflowed) begin
      state_o.byte_index = nxt.byte_index + CB'(1);
    end
  end

endmodule
